/* rtl/core/c0rf_pkg.sv */
// shared types and constants for the system coprocessor register file
// no dependencies; imported by c0rf_exec and cop0_register_file_step_top
package c0rf_pkg;

  typedef enum logic [2:0] {
    OP_MOVE_FROM    = 3'd0,
    OP_MOVE_TO      = 3'd1,
    OP_BR_FALSE     = 3'd2,
    OP_BR_TRUE      = 3'd3,
    OP_BR_FALSE_L   = 3'd4,
    OP_BR_TRUE_L    = 3'd5,
    OP_DISABLE_INT  = 3'd6
  } op_e;

  localparam logic [4:0] REG_COUNT  = 5'd9;
  localparam logic [4:0] REG_STATUS = 5'd12;
  localparam logic [4:0] REG_CONFIG = 5'd16;
  localparam logic [4:0] REG_DEBUG  = 5'd24;
  localparam logic [4:0] REG_PERF   = 5'd25;

  localparam logic [31:0] CONFIG_FIXED_MASK = 32'h0000_0FC0;
  localparam logic [31:0] CONFIG_FIXED_BITS = 32'h0000_0440;
  localparam logic [9:0]  DMA_COND_MASK     = 10'h3FF;
  localparam logic [31:0] DI_FORCE_MASK     = 32'h0002_0006;
  localparam logic [31:0] DI_MODE_MASK      = 32'h0000_0018;
  localparam logic [31:0] STATUS_IE         = 32'h0001_0000;
  localparam logic [15:0] PERF_SEL_MASK     = 16'h003E;

  typedef struct packed {
    op_e         operation;
    logic [4:0]  reg_index;
    logic [4:0]  target_gpr;
    logic [15:0] immediate;
    logic [31:0] write_value;
    logic [63:0] current_cycle;
    logic [31:0] instr_pc;
    logic [9:0]  dma_cis;
    logic [9:0]  dma_cpc;
  } item_t;

  typedef struct packed {
    logic        read_valid;
    logic [31:0] read_data;
    logic        branch_taken;
    logic [31:0] next_pc;
    logic        delay_slot_runs;
    logic        event_request;
  } result_t;

endpackage

/* rtl/core/cop0_register_file_step_top.sv */
// top level of the system coprocessor register file: input and result registers
// depends on c0rf_pkg and c0rf_exec
//
// Executes one coprocessor instruction per transfer: register reads and writes,
// the four DMA-condition branches and disable-interrupts. Throughput is one
// instruction per cycle while the output is not stalled. A result is offered
// once its instruction has passed the input register and a single register
// file pass into the result register. Every instruction gives exactly one
// result. State updates happen as an instruction leaves the input register,
// so results keep program order under any stall pattern on either side.
module cop0_register_file_step_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic [4:0]         reg_index_i,
  input  logic [4:0]         target_gpr_i,
  input  logic signed [15:0] immediate_i,
  input  logic [31:0]        write_value_i,
  input  logic [63:0]        current_cycle_i,
  input  logic [31:0]        instr_pc_i,
  input  logic [9:0]         dma_cis_i,
  input  logic [9:0]         dma_cpc_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               read_valid_o,
  output logic signed [31:0] read_data_o,
  output logic               branch_taken_o,
  output logic [31:0]        next_pc_o,
  output logic               delay_slot_runs_o,
  output logic               event_request_o
);
  import c0rf_pkg::*;

  logic    item_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t res_q;
  result_t res_d;
  logic    advance;
  logic    in_xfer;

  // result register can take a new value
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = item_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  c0rf_exec u_exec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (item_valid_q && advance),
    .item_i   (item_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= item_valid_q;
      end
      if (in_xfer) begin
        item_valid_q <= 1'b1;
      end else if (advance) begin
        item_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.operation     <= op_e'(operation_i);
      item_q.reg_index     <= reg_index_i;
      item_q.target_gpr    <= target_gpr_i;
      item_q.immediate     <= $unsigned(immediate_i);
      item_q.write_value   <= write_value_i;
      item_q.current_cycle <= current_cycle_i;
      item_q.instr_pc      <= instr_pc_i;
      item_q.dma_cis       <= dma_cis_i;
      item_q.dma_cpc       <= dma_cpc_i;
    end
    if (advance && item_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_valid_o      = res_q.read_valid;
  assign read_data_o       = $signed(res_q.read_data);
  assign branch_taken_o    = res_q.branch_taken;
  assign next_pc_o         = res_q.next_pc;
  assign delay_slot_runs_o = res_q.delay_slot_runs;
  assign event_request_o   = res_q.event_request;

endmodule

/* rtl/core/c0rf_exec.sv */
// register file state and single-pass execution of one coprocessor instruction
// depends on c0rf_pkg; state advances on fire_i
module c0rf_exec (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  c0rf_pkg::item_t  item_i,
  output c0rf_pkg::result_t result_o
);
  import c0rf_pkg::*;

  logic [31:0] regs_q [32];
  // only the low half of the stamp matters for the 32-bit count delta
  logic [31:0] stamp_q, stamp_d;
  logic        stamp_we;
  logic [31:0] perf_ctl_q, perf_cnt0_q, perf_cnt1_q;
  logic        perf_ctl_we, perf_cnt0_we, perf_cnt1_we;
  logic        wr_en;
  logic [4:0]  wr_idx;
  logic [31:0] wr_data;

  logic [31:0] count_now;
  logic [31:0] rd_val;
  logic        rd_ok;
  logic        cond, want_true, taken;
  logic [31:0] br_off;
  logic [31:0] status;

  assign count_now = regs_q[REG_COUNT] + item_i.current_cycle[31:0] - stamp_q;
  assign cond      = ((item_i.dma_cis | ~item_i.dma_cpc) & DMA_COND_MASK) == DMA_COND_MASK;
  assign want_true = (item_i.operation == OP_BR_TRUE) || (item_i.operation == OP_BR_TRUE_L);
  assign taken     = (cond == want_true);
  assign br_off    = {{14{item_i.immediate[15]}}, item_i.immediate, 2'b00};
  assign status    = regs_q[REG_STATUS];

  always_comb begin
    result_o     = '0;
    result_o.delay_slot_runs = 1'b1;
    wr_en        = 1'b0;
    wr_idx       = item_i.reg_index;
    wr_data      = item_i.write_value;
    stamp_we     = 1'b0;
    stamp_d      = item_i.current_cycle[31:0];
    perf_ctl_we  = 1'b0;
    perf_cnt0_we = 1'b0;
    perf_cnt1_we = 1'b0;
    rd_ok        = 1'b1;
    rd_val       = regs_q[item_i.reg_index];

    case (item_i.operation)
      OP_MOVE_FROM: begin
        case (item_i.reg_index)
          REG_COUNT: begin
            rd_val   = count_now;
            wr_en    = 1'b1;
            wr_data  = count_now;
            stamp_we = 1'b1;
          end
          REG_DEBUG: begin
            rd_ok = 1'b0;
          end
          REG_PERF: begin
            if (!item_i.immediate[0]) begin
              rd_val = perf_ctl_q;
            end else if (item_i.immediate[1]) begin
              rd_val = perf_cnt1_q;
            end else begin
              rd_val = perf_cnt0_q;
            end
          end
          default: ;
        endcase
        if (rd_ok && (item_i.target_gpr != 5'd0)) begin
          result_o.read_valid = 1'b1;
          result_o.read_data  = rd_val;
        end
      end
      OP_MOVE_TO: begin
        case (item_i.reg_index)
          REG_COUNT: begin
            wr_en    = 1'b1;
            stamp_we = 1'b1;
          end
          REG_STATUS: begin
            wr_en = 1'b1;
            result_o.event_request = 1'b1;
          end
          REG_CONFIG: begin
            wr_en   = 1'b1;
            wr_data = (item_i.write_value & ~CONFIG_FIXED_MASK) | CONFIG_FIXED_BITS;
          end
          REG_PERF: begin
            if (!item_i.immediate[0]) begin
              perf_ctl_we = ((item_i.immediate & PERF_SEL_MASK) == 16'd0);
            end else if (item_i.immediate[1]) begin
              perf_cnt1_we = 1'b1;
            end else begin
              perf_cnt0_we = 1'b1;
            end
          end
          REG_DEBUG: ;
          default: begin
            wr_en = 1'b1;
          end
        endcase
      end
      OP_BR_FALSE, OP_BR_TRUE, OP_BR_FALSE_L, OP_BR_TRUE_L: begin
        result_o.branch_taken = taken;
        result_o.next_pc = taken ? (item_i.instr_pc + br_off) : (item_i.instr_pc + 32'd4);
        if ((item_i.operation == OP_BR_FALSE_L) || (item_i.operation == OP_BR_TRUE_L)) begin
          result_o.delay_slot_runs = taken;
        end
      end
      OP_DISABLE_INT: begin
        // kernel mode, exception / error level, or status bit 17 allows the clear
        if (((status & DI_FORCE_MASK) != 32'd0) || ((status & DI_MODE_MASK) == 32'd0)) begin
          wr_en   = 1'b1;
          wr_idx  = REG_STATUS;
          wr_data = status & ~STATUS_IE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) begin
        regs_q[i] <= '0;
      end
      stamp_q     <= '0;
      perf_ctl_q  <= '0;
      perf_cnt0_q <= '0;
      perf_cnt1_q <= '0;
    end else if (fire_i) begin
      if (wr_en) begin
        regs_q[wr_idx] <= wr_data;
      end
      if (stamp_we) begin
        stamp_q <= stamp_d;
      end
      if (perf_ctl_we) begin
        perf_ctl_q <= item_i.write_value;
      end
      if (perf_cnt0_we) begin
        perf_cnt0_q <= item_i.write_value;
      end
      if (perf_cnt1_we) begin
        perf_cnt1_q <= item_i.write_value;
      end
    end
  end

endmodule
